/* src/three_channel_scalar_kalman_filter_core_assert.svh */
// Assertion macros shared by the Kalman filter core.
`ifndef THREE_CHANNEL_SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH
`define THREE_CHANNEL_SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KF3_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kf3 assertion failed");

// Next-cycle implication, checked outside reset.
`define KF3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kf3 assertion failed");

`endif

/* src/kf3_pkg.sv */
// Types and constants shared by the Kalman filter core and its iterative unit.
package kf3_pkg;

    localparam int NUM_CH    = 3;
    localparam int CH_W      = $clog2(NUM_CH);
    localparam int DATA_W    = 32;
    localparam int WIDE_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W + 1;
    localparam int CFG_IDX_W = 4;
    localparam int STEP_W    = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd429497;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RESET = 32'd21474836;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 4'd1;

    typedef enum logic {
        ITU_MUL = 1'b0,
        ITU_DIV = 1'b1
    } itu_op_t;

    typedef struct packed {
        logic    start;
        itu_op_t op;
    } itu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } itu_sts_t;

endpackage

/* src/kf3_itu.sv */
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
module kf3_itu (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  kf3_pkg::itu_ctl_t              ctl,
    input  logic [kf3_pkg::WIDE_W-1:0]     a_in,
    input  logic [kf3_pkg::DATA_W-1:0]     b_in,
    output kf3_pkg::itu_sts_t              sts,
    output logic [kf3_pkg::PROD_W-1:0]     result
);
    import kf3_pkg::*;

    // hi holds the running product high part or the partial remainder;
    // lo holds the multiplier bits or the quotient bits.
    logic [WIDE_W:0]   hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [WIDE_W-1:0] a_reg;
    itu_op_t           op_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;

    logic [WIDE_W:0]   mul_sum;
    logic [WIDE_W:0]   div_shift;
    logic [WIDE_W+1:0] div_diff;
    logic              div_ge;

    always_comb begin
        mul_sum   = {1'b0, hi_reg[WIDE_W-1:0]} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        div_shift = {hi_reg[WIDE_W-1:0], 1'b0};
        div_diff  = {1'b0, div_shift} - {2'b00, a_reg};
        div_ge    = ~div_diff[WIDE_W+1];
        if (op_reg == ITU_MUL) begin
            hi_next = {1'b0, mul_sum[WIDE_W:1]};
            lo_next = {mul_sum[0], lo_reg[DATA_W-1:1]};
        end else begin
            hi_next = div_ge ? div_diff[WIDE_W:0] : div_shift;
            lo_next = {lo_reg[DATA_W-2:0], div_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg  <= a_in;
            op_reg <= ctl.op;
            if (ctl.op == ITU_MUL) begin
                hi_reg <= '0;
                lo_reg <= b_in;
            end else begin
                hi_reg <= {2'b00, b_in};
                lo_reg <= '0;
            end
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = {hi_reg[WIDE_W-1:0], lo_reg};

endmodule

/* src/three_channel_scalar_kalman_filter_core.sv */
// Top level of the three-channel scalar Kalman filter core.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    temp_sample, humi_sample, dust_sample (Q16.16)
//  m_        out        m_valid / m_ready    temp_filtered, humi_filtered, dust_filtered
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data (process / measure noise)
//
// An item passes from the idle state through the channels one after another to a flush
// state that copies the estimates out. A channel first predicts its variance, then runs
// three jobs on the shared multiply/divide unit (gain division, correction product,
// variance product): issue, 32 steps, done. Zero measurement noise skips the division.
// Reset is synchronous and active low. Input is not ready while an item is in work; an
// untaken result holds the copy.
module three_channel_scalar_kalman_filter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [kf3_pkg::DATA_W-1:0] s_temp_sample,
    input  logic signed [kf3_pkg::DATA_W-1:0] s_humi_sample,
    input  logic signed [kf3_pkg::DATA_W-1:0] s_dust_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [kf3_pkg::DATA_W-1:0] m_temp_filtered,
    output logic signed [kf3_pkg::DATA_W-1:0] m_humi_filtered,
    output logic signed [kf3_pkg::DATA_W-1:0] m_dust_filtered,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kf3_pkg::DATA_W-1:0]        cfg_data
);
    import kf3_pkg::*;

    `include "three_channel_scalar_kalman_filter_core_assert.svh"

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PRED   = 9'b000000010,
        S_GAIN   = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_CORR   = 9'b000010000,
        S_MUL1   = 9'b000100000,
        S_EST    = 9'b001000000,
        S_MUL2   = 9'b010000000,
        S_FLUSH  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [DATA_W-1:0] q_reg, r_reg;

    // Channel state. The arrays rotate by one after each channel so that the
    // channel being worked on always sits at entry zero.
    logic signed [DATA_W-1:0] est_reg  [NUM_CH];
    logic        [DATA_W-1:0] var_reg  [NUM_CH];
    logic signed [DATA_W-1:0] samp_reg [NUM_CH];
    logic [CH_W-1:0]          ch_reg;

    // Per-channel working values.
    logic [DATA_W-1:0]        pp_reg;
    logic signed [WIDE_W-1:0] diff_reg;
    logic [WIDE_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        k_reg;
    logic [WIDE_W-1:0]        corr_reg;

    // Output register.
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] out_reg [NUM_CH];

    // Shared unit.
    itu_ctl_t          itu_ctl;
    itu_sts_t          itu_sts;
    logic [WIDE_W-1:0] itu_a;
    logic [DATA_W-1:0] itu_b;
    logic [PROD_W-1:0] itu_res;

    kf3_itu u_itu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (itu_ctl),
        .a_in    (itu_a),
        .b_in    (itu_b),
        .sts     (itu_sts),
        .result  (itu_res)
    );

    // Combinational helpers.
    logic [DATA_W:0]          pp_sum;
    logic [DATA_W-1:0]        pp_sat;
    logic [PROD_W-1:0]        corr_round;
    logic signed [DATA_W+2:0] est_wide;
    logic signed [DATA_W+2:0] est_sum;
    logic signed [DATA_W-1:0] est_sat;
    logic [WIDE_W-1:0]        one_minus_k;
    logic                     in_accept;
    logic                     last_ch;
    logic                     out_free;

    assign in_accept = s_valid && s_ready;
    assign last_ch   = (ch_reg == CH_W'(NUM_CH - 1));
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        // Predicted variance, saturated.
        pp_sum = {1'b0, var_reg[0]} + {1'b0, q_reg};
        pp_sat = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];

        // Correction = round(|d| * K / 2^32), ties away from zero. The sum stays
        // below 2^64, so the product width holds it.
        corr_round = itu_res + PROD_W'(32'h8000_0000);

        // Estimate update with signed saturation.
        est_wide = {{3{est_reg[0][DATA_W-1]}}, est_reg[0]};
        if (neg_reg) begin
            est_sum = est_wide - {2'b00, corr_reg};
        end else begin
            est_sum = est_wide + {2'b00, corr_reg};
        end
        if (est_sum[DATA_W+2:DATA_W-1] == '0 || est_sum[DATA_W+2:DATA_W-1] == '1) begin
            est_sat = est_sum[DATA_W-1:0];
        end else if (est_sum[DATA_W+2]) begin
            est_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            est_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end

        one_minus_k = {1'b1, {DATA_W{1'b0}}} - {1'b0, k_reg};
    end

    // Sequencer and shared-unit issue.
    always_comb begin
        state_next    = state_reg;
        itu_ctl.start = 1'b0;
        itu_ctl.op    = ITU_MUL;
        itu_a         = mag_reg;
        itu_b         = k_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PRED;
                end
            end
            S_PRED: begin
                state_next = S_GAIN;
            end
            S_GAIN: begin
                // Zero measurement noise skips the division.
                if (r_reg == '0) begin
                    state_next = S_CORR;
                end else begin
                    itu_ctl.start = 1'b1;
                    itu_ctl.op    = ITU_DIV;
                    itu_a         = {1'b0, pp_reg} + {1'b0, r_reg};
                    itu_b         = pp_reg;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (itu_sts.done) begin
                    state_next = S_CORR;
                end
            end
            S_CORR: begin
                itu_ctl.start = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1: begin
                if (itu_sts.done) begin
                    state_next = S_EST;
                end
            end
            S_EST: begin
                itu_ctl.start = 1'b1;
                itu_a         = one_minus_k;
                itu_b         = pp_reg;
                state_next    = S_MUL2;
            end
            S_MUL2: begin
                if (itu_sts.done) begin
                    state_next = last_ch ? S_FLUSH : S_PRED;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            q_reg       <= PROCESS_NOISE_RESET;
            r_reg       <= MEASURE_NOISE_RESET;
            m_valid_reg <= 1'b0;
            ch_reg      <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                est_reg[i] <= '0;
                var_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE: q_reg <= cfg_data;
                    REG_MEASURE_NOISE: r_reg <= cfg_data;
                    default: ;
                endcase
            end

            // A new result enters the output register only when the old one is
            // gone or leaves in this same cycle.
            if (state_reg == S_FLUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (in_accept) begin
                ch_reg <= '0;
            end

            // The variance product finishes a channel: write back and rotate.
            if (state_reg == S_MUL2 && itu_sts.done) begin
                for (int i = 0; i < NUM_CH - 1; i++) begin
                    est_reg[i] <= est_reg[i+1];
                    var_reg[i] <= var_reg[i+1];
                end
                est_reg[NUM_CH-1] <= est_sat;
                var_reg[NUM_CH-1] <= itu_res[2*DATA_W-1:DATA_W];
                ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            samp_reg[0] <= s_temp_sample;
            samp_reg[1] <= s_humi_sample;
            samp_reg[2] <= s_dust_sample;
        end else if (state_reg == S_MUL2 && itu_sts.done) begin
            for (int i = 0; i < NUM_CH - 1; i++) begin
                samp_reg[i] <= samp_reg[i+1];
            end
            samp_reg[NUM_CH-1] <= samp_reg[0];
        end

        if (state_reg == S_PRED) begin
            pp_reg   <= pp_sat;
            diff_reg <= {samp_reg[0][DATA_W-1], samp_reg[0]}
                      - {est_reg[0][DATA_W-1], est_reg[0]};
        end

        if (state_reg == S_GAIN) begin
            neg_reg <= diff_reg[WIDE_W-1];
            mag_reg <= diff_reg[WIDE_W-1] ? (WIDE_W)'(-diff_reg) : diff_reg;
            if (r_reg == '0) begin
                k_reg <= (pp_reg == '0) ? '0 : '1;
            end
        end

        if (state_reg == S_DIV && itu_sts.done) begin
            k_reg <= itu_res[DATA_W-1:0];
        end

        if (state_reg == S_MUL1 && itu_sts.done) begin
            corr_reg <= corr_round[PROD_W-1:DATA_W];
        end

        if (state_reg == S_FLUSH && out_free) begin
            for (int i = 0; i < NUM_CH; i++) begin
                out_reg[i] <= est_reg[i];
            end
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_temp_filtered = out_reg[0];
    assign m_humi_filtered = out_reg[1];
    assign m_dust_filtered = out_reg[2];

    // The shared unit is never left running while a new item is taken.
    `KF3_ASSERT_NOW(a_idle_unit_free, aclk, aresetn, s_ready, !itu_sts.busy)
    // The unit only reports completion while the sequencer waits for it.
    `KF3_ASSERT_NOW(a_done_in_wait, aclk, aresetn, itu_sts.done,
        (state_reg == S_DIV || state_reg == S_MUL1 || state_reg == S_MUL2))
    // An accepted item starts at the first channel.
    `KF3_ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_accept,
        (state_reg == S_PRED && ch_reg == '0))

endmodule

/* sim/three_channel_scalar_kalman_filter_core_test.sv */
// Self-checking testbench for the three-channel scalar Kalman filter core.
`timescale 1ns / 100ps

module three_channel_scalar_kalman_filter_core_test;
    import kf3_pkg::*;

    // Signed Q16.16 samples and estimates, unsigned Q0.32 variances and noise values.
    typedef logic signed [DATA_W-1:0] q16_16_t;
    typedef logic [DATA_W-1:0]        uq0_32_t;

    // One item: a value per channel, channel 0 (temperature) leftmost in a literal.
    typedef logic [0:NUM_CH-1][DATA_W-1:0] reading_t;

    localparam int CH_TEMP = 0;
    localparam int CH_HUMI = 1;
    localparam int CH_DUST = 2;

    // Writes to these indexes must leave both noise registers untouched.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HIGH = 4'd15;

    localparam q16_16_t Q16_MAX    = 32'sh7FFF_FFFF;
    localparam q16_16_t Q16_MIN    = 32'sh8000_0000;
    localparam q16_16_t Q16_ONE    = 32'sh0001_0000;
    localparam q16_16_t Q16_ZERO   = 32'sh0000_0000;
    localparam q16_16_t NOISE_SPAN = 32'sh0004_0000;

    localparam longint ESTIMATE_MAX = 64'sd2147483647;
    localparam longint ESTIMATE_MIN = -64'sd2147483648;

    // Time for one item: three channels on the shared iterative unit, plus the
    // idle state and the flush state that copies the estimates out.
    localparam int ITEM_LATENCY           = 3 * 103 + 2;
    localparam int LONG_HOLD_CYCLES       = 2500;
    localparam int RANDOM_ITEMS_PER_PHASE = 140;
    localparam int CYCLE_LIMIT            = 2_000_000;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;

    logic    s_valid = 1'b0;
    logic    s_ready;
    q16_16_t s_temp_sample = '0;
    q16_16_t s_humi_sample = '0;
    q16_16_t s_dust_sample = '0;

    logic    m_valid;
    logic    m_ready = 1'b0;
    q16_16_t m_temp_filtered;
    q16_16_t m_humi_filtered;
    q16_16_t m_dust_filtered;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    uq0_32_t              cfg_data = '0;

    // Filter model: its own copy of the noise registers and the per-channel state.
    uq0_32_t process_noise_model = PROCESS_NOISE_RESET;
    uq0_32_t measure_noise_model = MEASURE_NOISE_RESET;
    q16_16_t estimate_model [NUM_CH];
    uq0_32_t variance_model [NUM_CH];

    // Estimates predicted for accepted items, oldest first.
    reading_t pending_estimates [$];

    // Idling controls. The receiver reads stall_pct in its own process, so it is
    // written with nonblocking assignments to keep the change on a clean edge.
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    logic     hold_toggle = 1'b0;

    // Slowly moving signal level per channel for the sensor-like random items.
    q16_16_t  signal_level [NUM_CH];

    int       error_count = 0;
    string    channel_label [NUM_CH] = '{"temp", "humi", "dust"};

    three_channel_scalar_kalman_filter_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_temp_sample   (s_temp_sample),
        .s_humi_sample   (s_humi_sample),
        .s_dust_sample   (s_dust_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_temp_filtered (m_temp_filtered),
        .m_humi_filtered (m_humi_filtered),
        .m_dust_filtered (m_dust_filtered),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Runs one filter step on every channel of the model and returns the new
    // estimates. All arithmetic is exact integer arithmetic at 64 bits, which
    // holds every intermediate product of two 32-bit (or 33-bit) operands.
    function automatic reading_t advance_filter_model(input reading_t samples);
        reading_t       estimates;
        logic [DATA_W:0] pp_sum;
        uq0_32_t        pp;
        uq0_32_t        gain;
        logic [63:0]    denom;
        logic [63:0]    quotient;
        logic [63:0]    magnitude;
        logic [63:0]    product;
        longint         diff;
        longint         next_estimate;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            // Predicted variance saturates instead of wrapping.
            pp_sum = {1'b0, variance_model[ch]} + {1'b0, process_noise_model};
            pp     = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];

            // Gain is Pp / (Pp + R) in Q0.32. With Pp and R both zero there is
            // nothing to divide and the gain is zero; with R zero alone the
            // quotient reaches 2^32 and saturates.
            denom = 64'(pp) + 64'(measure_noise_model);
            if (denom == 64'd0) begin
                gain = '0;
            end else begin
                quotient = {pp, 32'd0} / denom;
                gain     = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[31:0];
            end

            // Correction is |d| * K rounded half away from zero, signed like d.
            diff      = longint'($signed(samples[ch])) - longint'(estimate_model[ch]);
            magnitude = (diff < 0) ? 64'(-diff) : 64'(diff);
            product   = magnitude * 64'(gain) + 64'h8000_0000;
            product   = product >> 32;
            if (diff < 0) begin
                next_estimate = longint'(estimate_model[ch]) - longint'(product);
            end else begin
                next_estimate = longint'(estimate_model[ch]) + longint'(product);
            end
            if (next_estimate > ESTIMATE_MAX) begin
                next_estimate = ESTIMATE_MAX;
            end
            if (next_estimate < ESTIMATE_MIN) begin
                next_estimate = ESTIMATE_MIN;
            end
            estimate_model[ch] = q16_16_t'(next_estimate);
            estimates[ch]      = estimate_model[ch];

            // New variance is floor((1 - K) * Pp), with 1 represented as 2^32.
            product            = (64'h1_0000_0000 - 64'(gain)) * 64'(pp);
            variance_model[ch] = product[63:32];
        end
        return estimates;
    endfunction

    // Noise setting for a random phase: the extremes, a fully random word, or a
    // small value of the size a real sensor setup would use.
    function automatic uq0_32_t pick_noise();
        case ($urandom_range(5))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return $urandom();
            end
            default: begin
                return $urandom_range(32'h0400_0000);
            end
        endcase
    endfunction

    // Mostly a noisy reading around a level that jumps now and then, so the
    // filters settle and track; the rest is full-range words and extremes.
    function automatic reading_t next_reading();
        reading_t reading;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if ($urandom_range(49) == 0) begin
                signal_level[ch] = q16_16_t'($urandom()) >>> 1;
            end
            case ($urandom_range(9))
                0: begin
                    reading[ch] = $urandom();
                end
                1: begin
                    reading[ch] = $urandom_range(1) ? Q16_MAX : Q16_MIN;
                end
                default: begin
                    reading[ch] = signal_level[ch] + q16_16_t'($urandom_range(NOISE_SPAN))
                                  - (NOISE_SPAN >>> 1);
                end
            endcase
        end
        return reading;
    endfunction

    // Offers one item after a random idle gap and records its predicted
    // estimates once the core takes it. Valid is left high on return, so the
    // caller either sends the next item at once or lowers valid in this step.
    task automatic send_reading(input reading_t reading);
        int gap;
        gap = 0;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        // Now and then a gap long enough to land anywhere in the core's work.
        if (send_idle_pct != 0 && $urandom_range(7) == 0) begin
            gap += $urandom_range(ITEM_LATENCY, 1);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_temp_sample <= reading[CH_TEMP];
        s_humi_sample <= reading[CH_HUMI];
        s_dust_sample <= reading[CH_DUST];
        do @(posedge aclk); while (!s_ready);
        pending_estimates.push_back(advance_filter_model(reading));
    endtask

    // Stops offering items and waits until every predicted result has come
    // back. The queue is looked at on the falling edge, clear of the checker.
    task automatic await_all_estimates();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_estimates.size() != 0);
        @(posedge aclk);
    endtask

    // Writes one configuration register. Only called while the core is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input uq0_32_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_PROCESS_NOISE: begin
                process_noise_model = value;
            end
            REG_MEASURE_NOISE: begin
                measure_noise_model = value;
            end
            default: begin
                // Unmapped indexes are ignored by the core.
            end
        endcase
    endtask

    task automatic set_noise(input uq0_32_t process_noise, input uq0_32_t measure_noise);
        await_all_estimates();
        write_register(REG_PROCESS_NOISE, process_noise);
        write_register(REG_MEASURE_NOISE, measure_noise);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct    <= receiver_pct;
    endtask

    // The noise defaults after reset, with the field extremes as samples. The
    // first item starts from zero estimates and zero variances.
    task automatic test_reset_defaults();
        send_reading({Q16_MAX, Q16_MIN, Q16_ZERO});
        send_reading({Q16_MIN, Q16_MAX, -Q16_ONE});
        send_reading({Q16_ONE, -Q16_ONE, 32'sd1});
        send_reading({Q16_ZERO, Q16_ZERO, Q16_MAX});
    endtask

    // Largest process noise on top of a nonzero variance overflows the
    // predicted variance; zero measurement noise drives the gain to its
    // ceiling, so the estimate jumps almost onto the sample and the variance
    // falls back to zero.
    task automatic test_full_gain_with_variance_overflow();
        set_noise('1, '0);
        send_reading({Q16_MIN, Q16_MAX, Q16_ONE});
        send_reading({Q16_MAX, Q16_MIN, -Q16_ONE});
    endtask

    // With the variance at zero and both noise values zero the gain has a
    // zero denominator and is taken as zero: estimates must not move.
    task automatic test_zero_gain_without_noise();
        set_noise('0, '0);
        send_reading({Q16_ONE, -Q16_ONE, Q16_MAX});
        send_reading({Q16_MIN, Q16_MAX, Q16_ZERO});
    endtask

    // Extremes of the legal register ranges, each with a pair of items.
    task automatic test_noise_extremes();
        set_noise(32'd1, '1);
        send_reading({Q16_MAX, Q16_MAX, Q16_MIN});
        send_reading({-Q16_ONE, Q16_ONE, Q16_ZERO});
        set_noise('0, 32'd1);
        send_reading({Q16_MIN, Q16_ZERO, Q16_MAX});
        send_reading({Q16_ONE, Q16_MIN, -Q16_ONE});
        set_noise('1, '1);
        send_reading({Q16_ZERO, Q16_MAX, Q16_MIN});
        send_reading({Q16_MAX, Q16_ONE, Q16_ONE});
    endtask

    // Writes to unmapped indexes; the following items show whether either
    // noise register changed.
    task automatic test_unmapped_register_writes();
        set_noise(32'd429497, 32'd21474836);
        send_reading({Q16_ONE, Q16_ONE, Q16_ONE});
        await_all_estimates();
        write_register(REG_UNMAPPED_LOW, '0);
        write_register(REG_UNMAPPED_HIGH, '1);
        send_reading({Q16_MAX, Q16_MIN, Q16_ZERO});
        send_reading({-Q16_ONE, Q16_MAX, Q16_MIN});
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // output register and the core fill up and the input has to stall.
    task automatic test_output_backpressure();
        set_noise(32'h0010_0000, 32'h0100_0000);
        set_idling(0, 0);
        hold_toggle <= ~hold_toggle;
        repeat (12) send_reading(next_reading());
    endtask

    // The sender stops until every result is back, then carries on.
    task automatic test_sender_pause();
        set_idling(30, 30);
        repeat (8) send_reading(next_reading());
        await_all_estimates();
        repeat (8) send_reading(next_reading());
    endtask

    // A stretch of random items under one idling mix, with a fresh random
    // noise setting at the start and halfway.
    task automatic test_random_phase(input int sender_pct, input int receiver_pct);
        set_idling(sender_pct, receiver_pct);
        for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
            if (n % (RANDOM_ITEMS_PER_PHASE / 2) == 0) begin
                set_noise(pick_noise(), pick_noise());
            end
            send_reading(next_reading());
        end
    endtask

    // Receiver: random stalls, plus a long hold-off each time the test flips
    // hold_toggle, counted down here cycle by cycle.
    initial begin : receive_side
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Every result taken is checked channel by channel against the oldest
    // prediction still waiting.
    always @(posedge aclk) begin : check_results
        reading_t got;
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_temp_filtered, m_humi_filtered, m_dust_filtered};
            if (pending_estimates.size() == 0) begin
                $display("%0t: result item with nothing expected: temp %0d humi %0d dust %0d",
                         $time, m_temp_filtered, m_humi_filtered, m_dust_filtered);
                error_count++;
            end else begin
                want = pending_estimates.pop_front();
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (got[ch] !== want[ch]) begin
                        $display("%0t: %s_filtered mismatch, expected %0d, actual %0d",
                                 $time, channel_label[ch], $signed(want[ch]),
                                 $signed(got[ch]));
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a run that has not finished by now is hung.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            estimate_model[ch] = '0;
            variance_model[ch] = '0;
            signal_level[ch]   = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part first, while the state is still known from reset.
        test_reset_defaults();
        test_full_gain_with_variance_overflow();
        test_zero_gain_without_noise();
        test_noise_extremes();
        test_unmapped_register_writes();
        test_output_backpressure();
        test_sender_pause();

        // Random part under each idling mix.
        test_random_phase(0, 0);
        test_random_phase(61, 0);
        test_random_phase(0, 61);
        test_random_phase(30, 30);

        // Let the last results drain, then watch a while for stray ones.
        await_all_estimates();
        repeat (2 * ITEM_LATENCY) @(posedge aclk);

        if (error_count == 0 && pending_estimates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
